/* design/tkrs_pkg.sv */
// ----------------------------------------------------------------------------
// tkrs_pkg
// Shared types, register indexes and the row ordering function of the top-k
// row selector.
// ----------------------------------------------------------------------------
package tkrs_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int KEY_BITS     = 64;
   localparam int CSR_DW       = 5;
   localparam int CSR_AW       = 2;

   // Configuration register indexes.
   localparam logic [CSR_AW-1:0] CSR_KEEP_COUNT  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_ASCENDING   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_NULLS_FIRST = 2'd2;

   // Item operations.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic                    operation;
      logic [KEY_BITS-1:0]     key;
      logic                    key_null;
      logic [PAYLOAD_BITS-1:0] payload;
   } req_type;

   typedef struct packed {
      logic                    row_valid;
      logic [KEY_BITS-1:0]     out_key;
      logic                    out_key_null;
      logic [PAYLOAD_BITS-1:0] out_payload;
      logic                    bound_valid;
      logic [KEY_BITS-1:0]     bound;
      logic                    bound_changed;
      logic                    last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_in;
      logic scan_start;
      logic scan_best;
      logic clear_used;
      logic write_fill;
      logic write_cand;
      logic fill_clear;
      logic out_add;
      logic out_row;
      logic out_empty;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_lt_k;
      logic emit_zero;
      logic scan_busy;
      logic new_better;
      logic out_free;
      logic last_row;
   } stat_type;

   // True when row a sorts strictly before row b.
   function automatic logic sorts_before(input logic [KEY_BITS-1:0] ka, input logic na,
                                         input logic [KEY_BITS-1:0] kb, input logic nb,
                                         input logic asc, input logic nf);
      logic r;
      if (na) begin
         r = nb ? 1'b0 : nf;
      end else if (nb) begin
         r = ~nf;
      end else if (asc) begin
         r = $signed(ka) < $signed(kb);
      end else begin
         r = $signed(ka) > $signed(kb);
      end
      return r;
   endfunction

endpackage

/* design/tkrs_dp.sv */
// ----------------------------------------------------------------------------
// tkrs_dp
// Datapath: row store, scan unit that finds the worst or the best unused row,
// configuration registers, bound history and the result register.
// ----------------------------------------------------------------------------
module tkrs_dp #(
   parameter int CAPACITY = tkrs_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tkrs_pkg::req_type           req_data,
   output tkrs_pkg::rsp_type           rsp_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        csr_we,
   input  logic [tkrs_pkg::CSR_AW-1:0] csr_index,
   input  logic [tkrs_pkg::CSR_DW-1:0] csr_wdata,
   input  tkrs_pkg::cmd_type           cmd,
   output tkrs_pkg::stat_type          stat
);
   import tkrs_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // Row store.
   logic [KEY_BITS-1:0]     mem_key_ff  [CAPACITY];
   logic                    mem_null_ff [CAPACITY];
   logic [PAYLOAD_BITS-1:0] mem_pay_ff  [CAPACITY];

   logic [CSR_DW-1:0] keep_count_ff;
   logic              ascending_ff, nulls_first_ff;
   logic [CW-1:0]     fill_ff, fill_in, k_eff, emit, cnt_ff, cnt_in;
   logic [CAPACITY-1:0] used_ff, used_in;

   req_type in_ff, in_in;

   // Scan unit.
   logic          act_ff, act_in, best_ff, best_in, rdv_ff, rdv_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic [AW-1:0] rdi_ff, rdi_in;
   logic [KEY_BITS-1:0]     rdk_ff;
   logic                    rdn_ff;
   logic [PAYLOAD_BITS-1:0] rdp_ff;
   logic                    cv_ff, cv_in, cn_ff, cn_in;
   logic [KEY_BITS-1:0]     ck_ff, ck_in;
   logic [PAYLOAD_BITS-1:0] cp_ff, cp_in;
   logic [AW-1:0]           ci_ff, ci_in;
   logic                    take;

   logic [KEY_BITS-1:0] rep_ff, rep_in;
   logic                rep_v_ff, rep_v_in;
   rsp_type rsp_ff, rsp_in;
   logic    rv_ff, rv_in, out_free, wr_en;
   logic [AW-1:0] wr_addr;

   // Effective count clamped to one..CAPACITY, and the drain length.
   always_comb begin
      if (keep_count_ff == '0) begin
         k_eff = CW'(1);
      end else if (32'(keep_count_ff) > CAPACITY) begin
         k_eff = CW'(CAPACITY);
      end else begin
         k_eff = CW'(keep_count_ff);
      end
      emit = (fill_ff < k_eff) ? fill_ff : k_eff;
   end

   // Candidate update: the worst scan keeps the lower slot on ties, the best
   // scan skips rows already drained and also keeps the lower slot.
   always_comb begin
      if (best_ff) begin
         take = rdv_ff && !used_ff[rdi_ff] &&
                (!cv_ff || sorts_before(rdk_ff, rdn_ff, ck_ff, cn_ff,
                                        ascending_ff, nulls_first_ff));
      end else begin
         take = rdv_ff && (!cv_ff || sorts_before(ck_ff, cn_ff, rdk_ff, rdn_ff,
                                                  ascending_ff, nulls_first_ff));
      end
   end

   assign out_free = !rv_ff || !rsp_stall;

   always_comb begin
      in_in    = in_ff;
      act_in   = act_ff;
      best_in  = best_ff;
      iss_in   = iss_ff;
      rdv_in   = act_ff;
      rdi_in   = iss_ff[AW-1:0];
      cv_in    = cv_ff;
      ck_in    = ck_ff;
      cn_in    = cn_ff;
      cp_in    = cp_ff;
      ci_in    = ci_ff;
      fill_in  = fill_ff;
      used_in  = used_ff;
      cnt_in   = cnt_ff;
      rep_in   = rep_ff;
      rep_v_in = rep_v_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff && rsp_stall;
      wr_en    = 1'b0;
      wr_addr  = ci_ff;

      if (cmd.load_in) begin
         in_in = req_data;
         if (req_data.key_null) begin
            in_in.key = '0;
         end
      end

      // Step the scan; issue one read a cycle until every held row is read.
      if (act_ff) begin
         iss_in = iss_ff + CW'(1);
         if (iss_ff + CW'(1) == fill_ff) begin
            act_in = 1'b0;
         end
      end
      if (take) begin
         cv_in = 1'b1;
         ck_in = rdk_ff;
         cn_in = rdn_ff;
         cp_in = rdp_ff;
         ci_in = rdi_ff;
      end
      if (cmd.scan_start) begin
         act_in  = (fill_ff != '0);
         best_in = cmd.scan_best;
         iss_in  = '0;
         cv_in   = 1'b0;
      end
      if (cmd.clear_used) begin
         used_in = '0;
         cnt_in  = '0;
      end

      // Store writes.
      if (cmd.write_fill) begin
         wr_en   = 1'b1;
         wr_addr = fill_ff[AW-1:0];
         fill_in = fill_ff + CW'(1);
      end
      if (cmd.write_cand) begin
         wr_en = 1'b1;
      end
      if (cmd.fill_clear) begin
         fill_in = '0;
      end

      // Result loading.
      if (cmd.out_add) begin
         rsp_in      = '0;
         rsp_in.last = 1'b1;
         rv_in       = 1'b1;
         if (!(fill_ff < k_eff)) begin
            rsp_in.bound_valid   = 1'b1;
            rsp_in.bound         = ck_ff;
            rsp_in.bound_changed = !rep_v_ff || (ck_ff != rep_ff);
            rep_in               = ck_ff;
            rep_v_in             = 1'b1;
         end
      end
      if (cmd.out_empty) begin
         rsp_in      = '0;
         rsp_in.last = 1'b1;
         rv_in       = 1'b1;
      end
      if (cmd.out_row) begin
         rsp_in              = '0;
         rsp_in.row_valid    = 1'b1;
         rsp_in.out_key      = ck_ff;
         rsp_in.out_key_null = cn_ff;
         rsp_in.out_payload  = cp_ff;
         rsp_in.last         = (cnt_ff + CW'(1) == emit);
         rv_in               = 1'b1;
         used_in[ci_ff]      = 1'b1;
         cnt_in              = cnt_ff + CW'(1);
      end
   end

   // Control and history registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff  <= CSR_DW'(16);
         ascending_ff   <= 1'b1;
         nulls_first_ff <= 1'b0;
         fill_ff        <= '0;
         act_ff         <= 1'b0;
         rdv_ff         <= 1'b0;
         rep_ff         <= '0;
         rep_v_ff       <= 1'b0;
         rv_ff          <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_KEEP_COUNT:  keep_count_ff  <= csr_wdata;
               CSR_ASCENDING:   ascending_ff   <= csr_wdata[0];
               CSR_NULLS_FIRST: nulls_first_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         fill_ff  <= fill_in;
         act_ff   <= act_in;
         rdv_ff   <= rdv_in;
         rep_ff   <= rep_in;
         rep_v_ff <= rep_v_in;
         rv_ff    <= rv_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      best_ff <= best_in;
      iss_ff  <= iss_in;
      rdi_ff  <= rdi_in;
      cv_ff   <= cv_in;
      ck_ff   <= ck_in;
      cn_ff   <= cn_in;
      cp_ff   <= cp_in;
      ci_ff   <= ci_in;
      used_ff <= used_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   // Row store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_key_ff[wr_addr]  <= in_ff.key;
         mem_null_ff[wr_addr] <= in_ff.key_null;
         mem_pay_ff[wr_addr]  <= in_ff.payload;
      end
      rdk_ff <= mem_key_ff[iss_ff[AW-1:0]];
      rdn_ff <= mem_null_ff[iss_ff[AW-1:0]];
      rdp_ff <= mem_pay_ff[iss_ff[AW-1:0]];
   end

   always_comb begin
      stat.fill_lt_k  = fill_ff < k_eff;
      stat.emit_zero  = (emit == '0);
      stat.scan_busy  = act_ff || rdv_ff;
      stat.new_better = sorts_before(in_ff.key, in_ff.key_null, ck_ff, cn_ff,
                                     ascending_ff, nulls_first_ff);
      stat.out_free   = out_free;
      stat.last_row   = (cnt_ff + CW'(1) == emit);
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rv_ff;

endmodule

/* design/tkrs_ctrl.sv */
// ----------------------------------------------------------------------------
// tkrs_ctrl
// Controller: sequences adds (fill or replace, then a bound scan once the store is full) and drains
// (one best-row scan per emitted row).
// ----------------------------------------------------------------------------
module tkrs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_op,
   output logic               req_stall,
   input  tkrs_pkg::stat_type stat,
   output tkrs_pkg::cmd_type  cmd
);
   import tkrs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WRITE, ST_REPLACE, ST_CHECK, ST_BOUND, ST_ADD_OUT,
      ST_DRAIN_SCAN, ST_DRAIN_OUT
   } state_type;

   state_type state_ff;
   logic      accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   // Command decode from the current state and status.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_in = 1'b1;
               if (req_op == OP_DRAIN) begin
                  cmd.clear_used = 1'b1;
                  cmd.scan_start = 1'b1;
                  cmd.scan_best  = 1'b1;
               end else if (!stat.fill_lt_k) begin
                  cmd.scan_start = 1'b1;
               end
            end
         end
         ST_WRITE: cmd.write_fill = 1'b1;
         ST_REPLACE: begin
            if (!stat.scan_busy && stat.new_better) begin
               cmd.write_cand = 1'b1;
            end
         end
         ST_CHECK: cmd.scan_start = !stat.fill_lt_k;
         ST_BOUND: ;
         ST_ADD_OUT: cmd.out_add = stat.out_free;
         ST_DRAIN_SCAN: ;
         ST_DRAIN_OUT: begin
            if (stat.emit_zero) begin
               cmd.out_empty  = stat.out_free;
               cmd.fill_clear = stat.out_free;
            end else if (stat.out_free) begin
               cmd.out_row    = 1'b1;
               cmd.fill_clear = stat.last_row;
               cmd.scan_start = !stat.last_row;
               cmd.scan_best  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_op == OP_DRAIN) begin
                     state_ff <= ST_DRAIN_SCAN;
                  end else if (stat.fill_lt_k) begin
                     state_ff <= ST_WRITE;
                  end else begin
                     state_ff <= ST_REPLACE;
                  end
               end
            end
            ST_WRITE: state_ff <= ST_CHECK;
            ST_REPLACE: begin
               if (!stat.scan_busy) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: state_ff <= stat.fill_lt_k ? ST_ADD_OUT : ST_BOUND;
            ST_BOUND: begin
               if (!stat.scan_busy) begin
                  state_ff <= ST_ADD_OUT;
               end
            end
            ST_ADD_OUT: begin
               if (stat.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DRAIN_SCAN: begin
               if (!stat.scan_busy) begin
                  state_ff <= ST_DRAIN_OUT;
               end
            end
            ST_DRAIN_OUT: begin
               if (stat.out_free) begin
                  if (stat.emit_zero || stat.last_row) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_DRAIN_SCAN;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* design/top_k_row_selector_core.sv */
// ----------------------------------------------------------------------------
// top_k_row_selector_core
// Keeps the best rows of a stream by a signed key with a null flag and drains
// them best-first on request.
//
//   channel | ports            | direction | carries
//   request | req_valid/stall  | in        | add or drain item
//   result  | rsp_valid/stall  | out       | bound or drained row
//   config  | csr_we/index     | in        | keep count, order, null place
//
// An add to a full store first scans for the worst row, reading the row store
// once per cycle through its single read port, then a second scan finds the
// new bound. A drain runs one full scan per emitted row. Reset is synchronous
// and empties the store at once. A stalled result holds its value; no new
// item is taken until the current one has loaded its last result into the
// result register.
// ----------------------------------------------------------------------------
module top_k_row_selector_core #(
   parameter int CAPACITY = tkrs_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tkrs_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tkrs_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [tkrs_pkg::CSR_AW-1:0] csr_index,
   input  logic [tkrs_pkg::CSR_DW-1:0] csr_wdata
);
   import tkrs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tkrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tkrs_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the top-k row selector. A directed table covers
// empty drains, key extremes, null placement, ties and count limits. Random
// phases of adds and drains follow under random register settings. Each result is
// compared field by field with a behavioural model of the kept-row store.
// ----------------------------------------------------------------------------
module testbench;
   import tkrs_pkg::*;

   localparam int CAP        = 16;
   localparam int WDOG_LIMIT = 4000;
   localparam int N_RANDOM   = 255;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      req_type               item;
      bit                    typed;
      rsp_type               exp;
      logic [CSR_AW-1:0]     idx;
      logic [CSR_DW-1:0]     val;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_index = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;

   // Model of the kept rows and registers.
   logic [63:0]         kept_key [CAP];
   bit                  kept_null [CAP];
   logic [31:0]         kept_pay [CAP];
   int unsigned         kept_fill;
   logic [63:0]         last_bound;
   bit                  bound_seen;
   logic [4:0]          cfg_keep;
   bit                  cfg_asc;
   bit                  cfg_nf;

   rsp_type             pending_rsp [$];
   stim_row_type        plan [$];
   int                  n_errors = 0;
   bit                  idling_on = 1'b1;
   bit                  long_hold_go = 1'b0;
   int                  quiet_cycles = 0;

   top_k_row_selector_core i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Appends one expected result to the tail of the queue.
   function automatic void queue_rsp(rsp_type r);
      pending_rsp = {pending_rsp, r};
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(stim_row_type s);
      plan = {plan, s};
   endfunction

   // Ordering of two rows: negative when a sorts before b.
   function automatic int row_order(logic [63:0] ka, bit na, logic [63:0] kb, bit nb);
      int r;
      if (na) begin
         r = nb ? 0 : (cfg_nf ? -1 : 1);
      end else if (nb) begin
         r = cfg_nf ? 1 : -1;
      end else begin
         r = ($signed(ka) < $signed(kb)) ? -1 : (($signed(ka) > $signed(kb)) ? 1 : 0);
         if (!cfg_asc) r = -r;
      end
      return r;
   endfunction

   function automatic int unsigned eff_keep();
      if (cfg_keep == 0) return 1;
      if (cfg_keep > CAP) return CAP;
      return 32'(cfg_keep);
   endfunction

   // Lowest slot wins among equally bad rows.
   function automatic int unsigned worst_row();
      int unsigned w;
      w = 0;
      for (int unsigned i = 1; i < kept_fill; i++) begin
         if (row_order(kept_key[i], kept_null[i], kept_key[w], kept_null[w]) > 0) w = i;
      end
      return w;
   endfunction

   // Updates the kept rows for one item and queues the results it causes.
   function automatic void predict_rows(req_type it);
      int unsigned k, slot, w, n, emit, best;
      logic [63:0] key, b;
      bit          used [CAP];
      rsp_type     r;
      k = eff_keep();
      if (it.operation == OP_ADD) begin
         key  = it.key_null ? 64'd0 : it.key;
         slot = CAP;
         if (kept_fill < k) begin
            slot = kept_fill;
            kept_fill++;
         end else begin
            w = worst_row();
            if (row_order(key, it.key_null, kept_key[w], kept_null[w]) < 0) slot = w;
         end
         if (slot < CAP) begin
            kept_key[slot]  = key;
            kept_null[slot] = it.key_null;
            kept_pay[slot]  = it.payload;
         end
         r = '0;
         if (kept_fill >= k) begin
            b               = kept_key[worst_row()];
            r.bound_valid   = 1'b1;
            r.bound         = b;
            r.bound_changed = !bound_seen || b != last_bound;
            last_bound      = b;
            bound_seen      = 1'b1;
         end
         r.last = 1'b1;
         queue_rsp(r);
      end else begin
         n    = kept_fill;
         emit = (n < k) ? n : k;
         if (emit == 0) begin
            r      = '0;
            r.last = 1'b1;
            queue_rsp(r);
         end
         foreach (used[i]) used[i] = 1'b0;
         for (int unsigned e = 0; e < emit; e++) begin
            best = CAP;
            for (int unsigned i = 0; i < n; i++) begin
               if (used[i]) continue;
               if (best == CAP ||
                   row_order(kept_key[i], kept_null[i], kept_key[best], kept_null[best]) < 0)
                  best = i;
            end
            used[best]     = 1'b1;
            r              = '0;
            r.row_valid    = 1'b1;
            r.out_key      = kept_key[best];
            r.out_key_null = kept_null[best];
            r.out_payload  = kept_pay[best];
            r.last         = (e + 1 == emit);
            queue_rsp(r);
         end
         kept_fill = 0;
      end
   endfunction

   task automatic flag_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
         n_errors++;
      end
   endtask

   task automatic compare_rsp(rsp_type e, rsp_type a);
      flag_field("row_valid", e.row_valid, a.row_valid);
      flag_field("out_key", e.out_key, a.out_key);
      flag_field("out_key_null", e.out_key_null, a.out_key_null);
      flag_field("out_payload", e.out_payload, a.out_payload);
      flag_field("bound_valid", e.bound_valid, a.bound_valid);
      flag_field("bound", e.bound, a.bound);
      flag_field("bound_changed", e.bound_changed, a.bound_changed);
      flag_field("last", e.last, a.last);
   endtask

   // Offers one item and waits until the block takes it.
   task automatic offer_item(req_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      predict_rows(it);
   endtask

   // Sometimes leaves the request side idle for a short burst.
   task automatic idle_gap();
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_item(req_type it);
      offer_item(it);
      idle_gap();
   endtask

   // Waits for every result, then writes one register.
   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] val);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_KEEP_COUNT:  cfg_keep = val;
         CSR_ASCENDING:   cfg_asc  = val[0];
         CSR_NULLS_FIRST: cfg_nf   = val[0];
         default: ;
      endcase
   endtask

   function automatic req_type mk(logic op, logic [63:0] key, logic nul, logic [31:0] pay);
      req_type it;
      it.operation = op;
      it.key       = key;
      it.key_null  = nul;
      it.payload   = pay;
      return it;
   endfunction

   function automatic stim_row_type item_row(req_type it);
      stim_row_type s;
      s.kind  = ROW_ITEM;
      s.item  = it;
      s.typed = 1'b0;
      s.exp   = '0;
      s.idx   = '0;
      s.val   = '0;
      return s;
   endfunction

   function automatic stim_row_type typed_row(req_type it, logic bv, logic [63:0] b, logic bc);
      stim_row_type s;
      s                   = item_row(it);
      s.typed             = 1'b1;
      s.exp.bound_valid   = bv;
      s.exp.bound         = b;
      s.exp.bound_changed = bc;
      s.exp.last          = 1'b1;
      return s;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] val);
      stim_row_type s;
      s      = item_row('0);
      s.kind = ROW_CSR;
      s.idx  = idx;
      s.val  = val;
      return s;
   endfunction

   function automatic logic [63:0] rand_key();
      case ($urandom_range(0, 3))
         0:       return {$urandom, $urandom};
         1:       return 64'(signed'($urandom_range(0, 8)) - 4);
         2:       return $urandom_range(0, 1) ? 64'h7fff_ffff_ffff_ffff
                                               : 64'h8000_0000_0000_0000;
         default: return 64'(signed'($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   // Result side: random stall bursts, one long hold, and the checker.
   initial begin
      int  burst;
      bit  held;
      burst = 0;
      held  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               n_errors++;
            end else begin
               compare_rsp(pending_rsp.pop_front(), rsp_data);
            end
         end
         if (long_hold_go && !held) begin
            held      = 1'b1;
            rsp_stall <= 1'b1;
            repeat (120) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (burst > 0) begin
            burst--;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Stimulus: directed table, then random phases.
   initial begin
      rsp_type      typed_exp;
      int           sent;
      kept_fill  = 0;
      last_bound = '0;
      bound_seen = 1'b0;
      cfg_keep   = 5'd16;
      cfg_asc    = 1'b1;
      cfg_nf     = 1'b0;
      foreach (kept_key[i]) begin
         kept_key[i]  = '0;
         kept_null[i] = 1'b0;
         kept_pay[i]  = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_row(typed_row(mk(OP_DRAIN, '0, 1'b0, '0), 1'b0, '0, 1'b0));
      add_row(typed_row(mk(OP_ADD, 64'h7fff_ffff_ffff_ffff, 1'b0, 32'hffff_ffff),
                        1'b0, '0, 1'b0));
      add_row(typed_row(mk(OP_ADD, 64'h8000_0000_0000_0000, 1'b0, 32'h0),
                        1'b0, '0, 1'b0));
      add_row(typed_row(mk(OP_ADD, '1, 1'b1, 32'h1234_5678), 1'b0, '0, 1'b0));
      add_row(item_row(mk(OP_DRAIN, '0, 1'b0, '0)));
      add_row(csr_row(CSR_KEEP_COUNT, 5'd1));
      add_row(typed_row(mk(OP_ADD, 64'd5, 1'b0, 32'd1), 1'b1, 64'd5, 1'b1));
      add_row(typed_row(mk(OP_ADD, 64'd5, 1'b0, 32'd2), 1'b1, 64'd5, 1'b0));
      add_row(item_row(mk(OP_ADD, 64'd3, 1'b0, 32'd3)));
      add_row(csr_row(CSR_ASCENDING, 5'd0));
      add_row(item_row(mk(OP_ADD, 64'h8000_0000_0000_0000, 1'b0, 32'd4)));
      add_row(csr_row(CSR_NULLS_FIRST, 5'd1));
      add_row(item_row(mk(OP_ADD, 64'd9, 1'b1, 32'd5)));
      add_row(item_row(mk(OP_DRAIN, '0, 1'b0, '0)));
      add_row(csr_row(CSR_KEEP_COUNT, 5'd0));
      add_row(item_row(mk(OP_ADD, 64'd7, 1'b0, 32'd6)));
      add_row(item_row(mk(OP_ADD, 64'd8, 1'b0, 32'd7)));
      add_row(item_row(mk(OP_DRAIN, '0, 1'b0, '0)));
      add_row(csr_row(CSR_KEEP_COUNT, 5'd31));
      add_row(item_row(mk(OP_ADD, 64'd1, 1'b1, 32'd8)));
      add_row(item_row(mk(OP_ADD, 64'd2, 1'b0, 32'd9)));
      add_row(item_row(mk(OP_ADD, 64'd2, 1'b0, 32'd10)));
      add_row(item_row(mk(OP_ADD, -64'sd2, 1'b0, 32'd11)));
      add_row(csr_row(CSR_KEEP_COUNT, 5'd2));
      add_row(item_row(mk(OP_ADD, 64'd2, 1'b0, 32'd12)));
      add_row(item_row(mk(OP_ADD, 64'd100, 1'b0, 32'd13)));
      add_row(item_row(mk(OP_DRAIN, '0, 1'b0, '0)));

      // The typed value is checked right at acceptance, before any idle gap,
      // while its result is still the newest one in the queue.
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            offer_item(plan[i].item);
            if (plan[i].typed) begin
               typed_exp = pending_rsp[$];
               if (typed_exp !== plan[i].exp) begin
                  $display("%0t: table row %0d, expected %h, actual %h", $time, i,
                           plan[i].exp, typed_exp);
                  n_errors++;
               end
               pending_rsp[$] = plan[i].exp;
            end
            idle_gap();
         end
      end

      // Random phases, each under a fresh setting of all registers.
      sent = 0;
      while (sent < N_RANDOM) begin
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_KEEP_COUNT, 5'd1);
            1:       write_reg(CSR_KEEP_COUNT, 5'd16);
            2:       write_reg(CSR_KEEP_COUNT, 5'($urandom_range(0, 31)));
            default: write_reg(CSR_KEEP_COUNT, 5'($urandom_range(2, 6)));
         endcase
         write_reg(CSR_ASCENDING, 5'($urandom_range(0, 1)));
         write_reg(CSR_NULLS_FIRST, 5'($urandom_range(0, 1)));
         repeat ($urandom_range(10, 40)) begin
            if (sent == 120) long_hold_go = 1'b1;
            if (sent >= N_RANDOM - 50) idling_on = 1'b0;
            send_item(mk($urandom_range(0, 9) == 0 ? OP_DRAIN : OP_ADD, rand_key(),
                         $urandom_range(0, 7) == 0, $urandom));
            sent++;
         end
         send_item(mk(OP_DRAIN, rand_key(), 1'($urandom_range(0, 1)), $urandom));
         sent++;
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (n_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
